[rtl/zss_pkg.sv]
package zss_pkg;

	// Stream shape
	localparam int unsigned MAX_BLOCK_BYTES = 65535;
	localparam int unsigned LENGTH_BITS     = 32;

	// Adler-32 modulus
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	// zlib header bytes
	localparam logic [7:0] ZLIB_CMF = 8'h78;
	localparam logic [7:0] ZLIB_FLG = 8'h01;

	// Item commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// Longest run of result bytes one item can cause
	localparam int unsigned MAX_RUN   = 11;
	localparam int unsigned RUN_CNT_W = 4;

	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;  // bytes[0] leaves first
		logic [RUN_CNT_W-1:0]    count;
		logic                    done;   // run ends with the last trailer byte
	} run_t;

endpackage

[rtl/zss_in_if.sv]
interface zss_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  data_byte;
	logic [31:0] stream_length;

	modport source (output valid, command, data_byte, stream_length, input ready);
	modport sink   (input valid, command, data_byte, stream_length, output ready);
endinterface

[rtl/zss_out_if.sv]
interface zss_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_done;

	modport source (output valid, out_byte, run_last, stream_done, input ready);
	modport sink   (input valid, out_byte, run_last, stream_done, output ready);
endinterface

[rtl/zss_engine.sv]
module zss_engine (
	input  logic          clk,
	input  logic          arst_n,
	zss_in_if.sink        item,
	input  logic          can_load,
	output logic          load_valid,
	output zss_pkg::run_t run
);

	logic [15:0]         sum_low_q, sum_high_q;
	zss_pkg::len_t       rem_q;
	logic [15:0]         blk_q;
	logic                open_q;

	logic [15:0]         sum_low_d, sum_high_d;
	zss_pkg::len_t       rem_d;
	logic [15:0]         blk_d;
	logic                open_d;

	logic                take;
	logic [63:0]         len_wide;
	zss_pkg::len_t       len_in;
	logic                need_hdr, big, last;
	logic [15:0]         blk_len, nlen;
	logic [16:0]         lo_sum, hi_sum;
	logic [15:0]         lo_new, hi_new;
	zss_pkg::len_t       rem_dec;
	logic [4:0][7:0]     hdr_b;
	logic [3:0][7:0]     trl_b;

	assign item.ready = can_load;
	assign take       = item.valid && can_load;

	assign len_wide = 64'(item.stream_length);
	assign len_in   = len_wide[zss_pkg::LENGTH_BITS-1:0];

	assign need_hdr = (blk_q == 16'd0);
	assign big      = (rem_q > zss_pkg::LENGTH_BITS'(zss_pkg::MAX_BLOCK_BYTES));
	assign blk_len  = big ? 16'(zss_pkg::MAX_BLOCK_BYTES) : rem_q[15:0];
	assign nlen     = ~blk_len;

	// Adler-32 step: each sum stays below twice the modulus, one subtract folds it
	assign lo_sum = {1'b0, sum_low_q} + {9'd0, item.data_byte};
	assign lo_new = (lo_sum >= zss_pkg::ADLER_MOD) ? 16'(lo_sum - zss_pkg::ADLER_MOD)
	                                               : lo_sum[15:0];
	assign hi_sum = {1'b0, sum_high_q} + {1'b0, lo_new};
	assign hi_new = (hi_sum >= zss_pkg::ADLER_MOD) ? 16'(hi_sum - zss_pkg::ADLER_MOD)
	                                               : hi_sum[15:0];

	assign rem_dec = rem_q - zss_pkg::LENGTH_BITS'(1);
	assign last    = (rem_dec == '0);

	assign hdr_b[0] = {7'd0, !big};
	assign hdr_b[1] = blk_len[7:0];
	assign hdr_b[2] = blk_len[15:8];
	assign hdr_b[3] = nlen[7:0];
	assign hdr_b[4] = nlen[15:8];

	assign trl_b[0] = hi_new[15:8];
	assign trl_b[1] = hi_new[7:0];
	assign trl_b[2] = lo_new[15:8];
	assign trl_b[3] = lo_new[7:0];

	always_comb begin
		sum_low_d  = sum_low_q;
		sum_high_d = sum_high_q;
		rem_d      = rem_q;
		blk_d      = blk_q;
		open_d     = open_q;
		load_valid = 1'b0;
		run        = '0;
		if (item.command == zss_pkg::CMD_START) begin
			sum_low_d    = 16'd1;
			sum_high_d   = 16'd0;
			blk_d        = 16'd0;
			load_valid   = item.valid;
			run.bytes[0] = zss_pkg::ZLIB_CMF;
			run.bytes[1] = zss_pkg::ZLIB_FLG;
			if (len_in == '0) begin
				// empty final block, then the trailer of an empty checksum
				run.bytes[2]  = 8'h01;
				run.bytes[3]  = 8'h00;
				run.bytes[4]  = 8'h00;
				run.bytes[5]  = 8'hFF;
				run.bytes[6]  = 8'hFF;
				run.bytes[7]  = 8'h00;
				run.bytes[8]  = 8'h00;
				run.bytes[9]  = 8'h00;
				run.bytes[10] = 8'h01;
				run.count     = zss_pkg::RUN_CNT_W'(11);
				run.done      = 1'b1;
				rem_d         = '0;
				open_d        = 1'b0;
			end else begin
				run.count = zss_pkg::RUN_CNT_W'(2);
				rem_d     = len_in;
				open_d    = 1'b1;
			end
		end else if (open_q) begin
			load_valid = item.valid;
			sum_low_d  = lo_new;
			sum_high_d = hi_new;
			rem_d      = rem_dec;
			run.done   = last;
			if (need_hdr) begin
				run.bytes[4:0] = hdr_b;
				run.bytes[5]   = item.data_byte;
				run.bytes[9:6] = trl_b;
				run.count      = last ? zss_pkg::RUN_CNT_W'(10) : zss_pkg::RUN_CNT_W'(6);
				blk_d          = blk_len - 16'd1;
			end else begin
				run.bytes[0]   = item.data_byte;
				run.bytes[4:1] = trl_b;
				run.count      = last ? zss_pkg::RUN_CNT_W'(5) : zss_pkg::RUN_CNT_W'(1);
				blk_d          = blk_q - 16'd1;
			end
			if (last) begin
				blk_d  = 16'd0;
				open_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q  <= 16'd1;
			sum_high_q <= 16'd0;
			rem_q      <= '0;
			blk_q      <= 16'd0;
			open_q     <= 1'b0;
		end else if (take) begin
			sum_low_q  <= sum_low_d;
			sum_high_q <= sum_high_d;
			rem_q      <= rem_d;
			blk_q      <= blk_d;
			open_q     <= open_d;
		end
	end

endmodule

[rtl/zss_serializer.sv]
module zss_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	input  zss_pkg::run_t run,
	output logic          can_load,
	zss_out_if.source     result
);

	logic [zss_pkg::MAX_RUN-1:0][7:0] bytes_q;
	logic [zss_pkg::RUN_CNT_W-1:0]    cnt_q;
	logic                             done_q;
	logic                             xfer, one_left;

	assign one_left = (cnt_q == zss_pkg::RUN_CNT_W'(1));
	assign xfer     = result.valid && result.ready;
	assign can_load = (cnt_q == '0) || (one_left && xfer);

	assign result.valid       = (cnt_q != '0);
	assign result.out_byte    = bytes_q[0];
	assign result.run_last    = one_left;
	assign result.stream_done = one_left && done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_valid && can_load) begin
			cnt_q <= run.count;
		end else if (xfer) begin
			cnt_q <= cnt_q - zss_pkg::RUN_CNT_W'(1);
		end
	end

	// Payload: load a fresh run or advance one byte per transfer
	always_ff @(posedge clk) begin
		if (load_valid && can_load) begin
			bytes_q <= run.bytes;
			done_q  <= run.done;
		end else if (xfer) begin
			for (int i = 0; i < zss_pkg::MAX_RUN - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
			bytes_q[zss_pkg::MAX_RUN-1] <= 8'h00;
		end
	end

endmodule

[rtl/zlib_stored_stream_wrapper.sv]
// The first result byte of an item is offered in the cycle after its input transfer.
// One result byte leaves per cycle while the receiver is ready. An item causes a run of
// bytes (1 for a plain data byte, 6 at a block start, up to 11) that the single-byte output
// serializer shifts out; a new item is taken when it is empty or as its last byte leaves.
// Reset (arst_n low, asynchronous): Adler sums go to 1 and 0, no stream is open, output empty.
module zlib_stored_stream_wrapper (
	input  logic      clk,
	input  logic      arst_n,
	zss_in_if.sink    item,
	zss_out_if.source result
);

	// Handoff between the stream engine and the output serializer.
	// The engine takes an item whenever the serializer can accept a new run,
	// which includes the cycle in which the previous run's last byte transfers.
	logic          load_valid;
	logic          can_load;
	zss_pkg::run_t run;

	// Stream state, Adler-32 update and block framing: builds the whole
	// byte run for one item combinationally. Dropped data loads nothing.
	zss_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.can_load   (can_load),
		.load_valid (load_valid),
		.run        (run)
	);

	// Output register: hold the run and shift it out one byte per transfer,
	// flag the last byte of the run and the final checksum byte.
	zss_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.run        (run),
		.can_load   (can_load),
		.result     (result)
	);

endmodule
